// File: hw/rtl/sarl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarl_pkg: shared types and constants of the session admission limiter
// Field widths, register indexes, verdict codes and the slot table layout.
// ----------------------------------------------------------------------------
package sarl_pkg;

  localparam int unsigned SESSION_SLOTS = 256;
  localparam int unsigned SLOT_BITS     = $clog2(SESSION_SLOTS);
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned CMP_BITS      = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [31:0] WINDOW_TICKS_RST   = 32'd1000;
  localparam logic [15:0] MAX_PER_WINDOW_RST = 16'd100;
  localparam logic [15:0] HEARTBEAT_ID_RST   = 16'd1;
  localparam logic [15:0] LOGIN_ID_RST       = 16'd2;
  localparam logic [15:0] ECHO_ID_RST        = 16'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_TICKS   = 3'd0,
    REG_MAX_PER_WINDOW = 3'd1,
    REG_HEARTBEAT_ID   = 3'd2,
    REG_LOGIN_ID       = 3'd3,
    REG_ECHO_ID        = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_AUTH = 2'd1,
    VERDICT_RATE = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [31:0] window_ticks;
    logic [15:0] max_per_window;
    logic [15:0] heartbeat_id;
    logic [15:0] login_id;
    logic [15:0] echo_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  session_slot;
    logic [15:0] msg_id;
    logic [31:0] req_id;
    logic [31:0] arrival_time;
    logic        is_authed;
  } in_beat_t;

  typedef struct packed {
    logic        admitted;
    logic [1:0]  verdict_code;
    logic [31:0] reply_req_id;
  } out_beat_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [15:0]          count;
  } entry_t;

  typedef struct packed {
    logic                 used;
    entry_t               entry;
  } tbl_rd_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    entry_t               entry;
  } tbl_wr_t;

endpackage

// File: hw/rtl/sarl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarl_if: message and verdict channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sarl_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  session_slot;
  logic [15:0] msg_id;
  logic [31:0] req_id;
  logic [31:0] arrival_time;
  logic        is_authed;

  modport source (
    output valid, session_slot, msg_id, req_id, arrival_time, is_authed,
    input  ready
  );
  modport sink (
    input  valid, session_slot, msg_id, req_id, arrival_time, is_authed,
    output ready
  );
endinterface

interface sarl_out_if;
  logic        valid;
  logic        ready;
  logic        admitted;
  logic [1:0]  verdict_code;
  logic [31:0] reply_req_id;

  modport source (
    output valid, admitted, verdict_code, reply_req_id,
    input  ready
  );
  modport sink (
    input  valid, admitted, verdict_code, reply_req_id,
    output ready
  );
endinterface

// File: hw/rtl/sarl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarl_cfg: configuration registers
// Window length, per-window limit and the three whitelisted message ids.
// ----------------------------------------------------------------------------
module sarl_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sarl_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sarl_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output sarl_pkg::cfg_t                      cfg_o
);

  sarl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sarl_pkg::REG_WINDOW_TICKS:   cfg_d.window_ticks   = cfg_wdata_i[31:0];
        sarl_pkg::REG_MAX_PER_WINDOW: cfg_d.max_per_window = cfg_wdata_i[15:0];
        sarl_pkg::REG_HEARTBEAT_ID:   cfg_d.heartbeat_id   = cfg_wdata_i[15:0];
        sarl_pkg::REG_LOGIN_ID:       cfg_d.login_id       = cfg_wdata_i[15:0];
        sarl_pkg::REG_ECHO_ID:        cfg_d.echo_id        = cfg_wdata_i[15:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks   <= sarl_pkg::WINDOW_TICKS_RST;
      cfg_q.max_per_window <= sarl_pkg::MAX_PER_WINDOW_RST;
      cfg_q.heartbeat_id   <= sarl_pkg::HEARTBEAT_ID_RST;
      cfg_q.login_id       <= sarl_pkg::LOGIN_ID_RST;
      cfg_q.echo_id        <= sarl_pkg::ECHO_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/sarl_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarl_table: per-session window table
// Synchronous memory of window start and count, registered read,
// with a flip-flop used flag per slot that reset clears at once.
// ----------------------------------------------------------------------------
module sarl_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [sarl_pkg::SLOT_BITS-1:0]    rd_addr_i,
  output sarl_pkg::tbl_rd_t                 rd_o,
  input  sarl_pkg::tbl_wr_t                 wr_i
);

  sarl_pkg::entry_t                        mem [sarl_pkg::SESSION_SLOTS];
  logic [sarl_pkg::SESSION_SLOTS-1:0]      used_q;
  sarl_pkg::tbl_rd_t                       rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rd_q.entry <= mem[rd_addr_i];
      rd_q.used  <= used_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.en) begin
      used_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_o = rd_q;

endmodule

// File: hw/rtl/sarl_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarl_policy: admission decision
// Authentication check, window expiry and count update for one message.
// ----------------------------------------------------------------------------
module sarl_policy (
  input  sarl_pkg::in_beat_t   item_i,
  input  sarl_pkg::cfg_t       cfg_i,
  input  sarl_pkg::tbl_rd_t    rd_i,
  output sarl_pkg::out_beat_t  res_o,
  output sarl_pkg::tbl_wr_t    wr_o
);

  logic                            is_hb;
  logic                            whitelisted;
  logic [sarl_pkg::TIME_BITS-1:0]  now;
  logic [sarl_pkg::TIME_BITS-1:0]  diff;
  logic                            expired;
  logic [15:0]                     cnt;

  always_comb begin
    is_hb       = (item_i.msg_id == cfg_i.heartbeat_id);
    whitelisted = is_hb || (item_i.msg_id == cfg_i.login_id)
                        || (item_i.msg_id == cfg_i.echo_id);
    now         = sarl_pkg::TIME_BITS'(item_i.arrival_time);
    diff        = now - rd_i.entry.start;
    expired     = !rd_i.used ||
                  (sarl_pkg::CMP_BITS'(diff) >= sarl_pkg::CMP_BITS'(cfg_i.window_ticks));
    cnt         = expired ? 16'd0 : rd_i.entry.count;

    res_o.admitted     = 1'b1;
    res_o.verdict_code = sarl_pkg::VERDICT_OK;
    res_o.reply_req_id = item_i.req_id;

    wr_o.en          = 1'b0;
    wr_o.addr        = sarl_pkg::SLOT_BITS'(item_i.session_slot);
    wr_o.entry.start = expired ? now : rd_i.entry.start;
    wr_o.entry.count = cnt;

    if (!whitelisted && !item_i.is_authed) begin
      res_o.admitted     = 1'b0;
      res_o.verdict_code = sarl_pkg::VERDICT_AUTH;
    end else if (!is_hb) begin
      wr_o.en = 1'b1;
      if (cnt < cfg_i.max_per_window) begin
        wr_o.entry.count = 16'(cnt + 16'd1);
      end else begin
        res_o.admitted     = 1'b0;
        res_o.verdict_code = sarl_pkg::VERDICT_RATE;
      end
    end
  end

endmodule

// File: hw/rtl/session_admission_rate_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_admission_rate_limiter_unit: per-session admission filter
// Each message beat yields one verdict beat carrying its request id. A message
// passes two states: the slot table read as it is taken in idle, then the
// decision and write-back in busy, so the block takes no new message until
// the last one's verdict is registered; a held verdict stretches the busy
// state until its output register frees. Reset clears the per-slot used flags
// at once, so the block accepts messages as soon as reset is released.
// ----------------------------------------------------------------------------
module session_admission_rate_limiter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sarl_in_if.sink                             in_i,
  sarl_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [sarl_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sarl_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  state_e               state_q, state_d;
  sarl_pkg::in_beat_t   item_q;
  sarl_pkg::out_beat_t  out_q;
  logic                 out_valid_q, out_valid_d;

  sarl_pkg::cfg_t       cfg;
  sarl_pkg::tbl_rd_t    tbl_rd;
  sarl_pkg::tbl_wr_t    pol_wr, tbl_wr;
  sarl_pkg::out_beat_t  pol_res;

  logic in_fire;
  logic done;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign done       = (state_q == ST_BUSY) && (!out_valid_q || out_o.ready);

  sarl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sarl_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (sarl_pkg::SLOT_BITS'(in_i.session_slot)),
    .rd_o      (tbl_rd),
    .wr_i      (tbl_wr)
  );

  sarl_policy u_policy (
    .item_i (item_q),
    .cfg_i  (cfg),
    .rd_i   (tbl_rd),
    .res_o  (pol_res),
    .wr_o   (pol_wr)
  );

  always_comb begin
    tbl_wr    = pol_wr;
    tbl_wr.en = pol_wr.en && done;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the message and the verdict
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.session_slot <= in_i.session_slot;
      item_q.msg_id       <= in_i.msg_id;
      item_q.req_id       <= in_i.req_id;
      item_q.arrival_time <= in_i.arrival_time;
      item_q.is_authed    <= in_i.is_authed;
    end
    if (done) begin
      out_q <= pol_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.admitted     = out_q.admitted;
  assign out_o.verdict_code = out_q.verdict_code;
  assign out_o.reply_req_id = out_q.reply_req_id;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_BUSY)
    else $error("accepted beat did not start a lookup");

  a_write_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |-> state_q == ST_BUSY && !in_fire)
    else $error("table written outside the decision cycle");

  a_verdict_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_BUSY)
    else $error("verdict beat appeared without a lookup");

  a_admit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.admitted == (out_q.verdict_code == sarl_pkg::VERDICT_OK))
    else $error("admitted flag disagrees with verdict");

endmodule

// File: sim/sarl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarl_checker: verdict prediction and comparison for the admission limiter
// Watches the message, verdict and register write ports, keeps its own copy of
// the registers and the per-slot window table, predicts the verdict of every
// accepted message beat and compares each verdict beat with the oldest one.
// ----------------------------------------------------------------------------
module sarl_checker
  import sarl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sarl_in_if                       msg_if,
  sarl_out_if                      vrd_if,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output int                       mismatch_cnt_o,
  output int                       pending_o,
  output int                       admit_cnt_o,
  output int                       auth_cnt_o,
  output int                       rate_cnt_o
);

  cfg_t                 regs;
  logic [TIME_BITS-1:0] win_start [SESSION_SLOTS];
  logic [15:0]          win_count [SESSION_SLOTS];
  logic                 slot_seen [SESSION_SLOTS];
  out_beat_t            verdicts_due [$];
  int                   mismatches = 0;
  int                   n_admit = 0;
  int                   n_auth = 0;
  int                   n_rate = 0;

  assign mismatch_cnt_o = mismatches;
  assign admit_cnt_o    = n_admit;
  assign auth_cnt_o     = n_auth;
  assign rate_cnt_o     = n_rate;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want, input logic [31:0] req);
    $display("%0t ns: %s mismatch on verdict for req %08h: got %0h, expected %0h",
             $time, field, req, got, want);
    mismatches++;
  endtask

  function automatic out_beat_t judge_message(input in_beat_t m);
    logic [SLOT_BITS-1:0] s;
    logic [TIME_BITS-1:0] age;
    logic                 listed;
    out_beat_t            v;
    s = m.session_slot[SLOT_BITS-1:0];
    v.admitted     = 1'b1;
    v.verdict_code = VERDICT_OK;
    v.reply_req_id = m.req_id;
    listed = (m.msg_id == regs.heartbeat_id) || (m.msg_id == regs.login_id) ||
             (m.msg_id == regs.echo_id);
    if (!listed && !m.is_authed) begin
      v.admitted     = 1'b0;
      v.verdict_code = VERDICT_AUTH;
    end else if (m.msg_id != regs.heartbeat_id) begin
      age = m.arrival_time[TIME_BITS-1:0] - win_start[s];
      // restart the window on first use or once it has run out
      if (!slot_seen[s] || age >= regs.window_ticks) begin
        win_start[s] = m.arrival_time[TIME_BITS-1:0];
        win_count[s] = '0;
        slot_seen[s] = 1'b1;
      end
      if (win_count[s] < regs.max_per_window) begin
        win_count[s] = win_count[s] + 16'd1;
      end else begin
        v.admitted     = 1'b0;
        v.verdict_code = VERDICT_RATE;
      end
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    in_beat_t  m;
    out_beat_t want;
    if (!rst_ni) begin
      regs.window_ticks   = WINDOW_TICKS_RST;
      regs.max_per_window = MAX_PER_WINDOW_RST;
      regs.heartbeat_id   = HEARTBEAT_ID_RST;
      regs.login_id       = LOGIN_ID_RST;
      regs.echo_id        = ECHO_ID_RST;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        win_start[i] = '0;
        win_count[i] = '0;
        slot_seen[i] = 1'b0;
      end
      verdicts_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WINDOW_TICKS:   regs.window_ticks   = cfg_wdata_i[31:0];
          REG_MAX_PER_WINDOW: regs.max_per_window = cfg_wdata_i[15:0];
          REG_HEARTBEAT_ID:   regs.heartbeat_id   = cfg_wdata_i[15:0];
          REG_LOGIN_ID:       regs.login_id       = cfg_wdata_i[15:0];
          REG_ECHO_ID:        regs.echo_id        = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (msg_if.valid && msg_if.ready) begin
        m.session_slot = msg_if.session_slot;
        m.msg_id       = msg_if.msg_id;
        m.req_id       = msg_if.req_id;
        m.arrival_time = msg_if.arrival_time;
        m.is_authed    = msg_if.is_authed;
        verdicts_due.push_back(judge_message(m));
      end
      if (vrd_if.valid && vrd_if.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected beat", vrd_if.reply_req_id, '0, vrd_if.reply_req_id);
        end else begin
          want = verdicts_due.pop_front();
          if (vrd_if.admitted !== want.admitted)
            report_mismatch("admitted", 32'(vrd_if.admitted), 32'(want.admitted),
                            want.reply_req_id);
          if (vrd_if.verdict_code !== want.verdict_code)
            report_mismatch("verdict_code", 32'(vrd_if.verdict_code),
                            32'(want.verdict_code), want.reply_req_id);
          if (vrd_if.reply_req_id !== want.reply_req_id)
            report_mismatch("reply_req_id", vrd_if.reply_req_id, want.reply_req_id,
                            want.reply_req_id);
          case (verdict_e'(want.verdict_code))
            VERDICT_OK:   n_admit++;
            VERDICT_AUTH: n_auth++;
            default:      n_rate++;
          endcase
        end
      end
      pending_o <= verdicts_due.size();
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top of the session admission rate limiter
// Drives message beats and register writes, stalls both channels at random,
// and gives the verdict from the checker's mismatch count. A directed part
// covers whitelisting, window wrap and expiry, zero window and zero limit;
// random phases with windowed traffic on a few hot slots follow.
// ----------------------------------------------------------------------------
module tb_top;
  import sarl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  sarl_in_if  msg_bus ();
  sarl_out_if vrd_bus ();

  int          mismatch_cnt;
  int          pending;
  int          n_admit;
  int          n_auth;
  int          n_rate;
  int          cycle_cnt  = 0;
  int          stall_left = 0;
  int          n_msgs     = 0;
  int          n_settings = 0;
  bit          src_gaps   = 1'b1;
  bit          snk_gaps   = 1'b1;
  logic [15:0] cur_hb     = HEARTBEAT_ID_RST;
  logic [15:0] cur_login  = LOGIN_ID_RST;
  logic [15:0] cur_echo   = ECHO_ID_RST;

  session_admission_rate_limiter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (msg_bus),
    .out_o       (vrd_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sarl_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .msg_if         (msg_bus),
    .vrd_if         (vrd_bus),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .admit_cnt_o    (n_admit),
    .auth_cnt_o     (n_auth),
    .rate_cnt_o     (n_rate)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt, pending);
      $display("status: fail");
      $finish;
    end
  end

  // stall the verdict side in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      vrd_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (snk_gaps && $urandom_range(0, 7) == 0) begin
      vrd_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 8);
    end else begin
      vrd_bus.ready <= 1'b1;
    end
  end

  task automatic send_msg(input logic [7:0] slot, input logic [15:0] id,
                          input logic [31:0] req, input logic [31:0] at,
                          input logic authed);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      msg_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    msg_bus.valid        <= 1'b1;
    msg_bus.session_slot <= slot;
    msg_bus.msg_id       <= id;
    msg_bus.req_id       <= req;
    msg_bus.arrival_time <= at;
    msg_bus.is_authed    <= authed;
    do @(posedge clk_i); while (!msg_bus.ready);
    n_msgs++;
  endtask

  // hold off until every verdict is back
  task automatic quiesce();
    msg_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [31:0] win, input logic [15:0] lim,
                           input logic [15:0] hb, input logic [15:0] login,
                           input logic [15:0] echo);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_WINDOW_TICKS;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MAX_PER_WINDOW;
    cfg_wdata_i <= {16'h0, lim};
    @(posedge clk_i);
    cfg_idx_i   <= REG_HEARTBEAT_ID;
    cfg_wdata_i <= {16'h0, hb};
    @(posedge clk_i);
    cfg_idx_i   <= REG_LOGIN_ID;
    cfg_wdata_i <= {16'h0, login};
    @(posedge clk_i);
    cfg_idx_i   <= REG_ECHO_ID;
    cfg_wdata_i <= {16'h0, echo};
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_hb    = hb;
    cur_login = login;
    cur_echo  = echo;
    n_settings++;
  endtask

  task automatic run_phase(input int n_items, input int unsigned step_hi, input bit gaps);
    logic [7:0]  hot [4];
    logic [7:0]  slot;
    logic [31:0] t;
    logic [31:0] at;
    logic [15:0] id;
    int          r;
    src_gaps = gaps;
    snk_gaps <= gaps;
    foreach (hot[i]) hot[i] = 8'($urandom_range(0, 255));
    t = $urandom;
    repeat (n_items) begin
      r = $urandom_range(0, 19);
      // jump now and then, and let a few beats arrive out of time order
      if (r == 0) t = $urandom;
      else t = t + $urandom_range(0, step_hi);
      at = (r == 1) ? t - $urandom_range(0, step_hi) : t;
      case ($urandom_range(0, 9))
        0:       id = cur_hb;
        1:       id = cur_login;
        2:       id = cur_echo;
        8, 9:    id = 16'($urandom_range(0, 65535));
        default: id = 16'h0100 + 16'($urandom_range(0, 3));
      endcase
      slot = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
      send_msg(slot, id, $urandom, at, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    msg_bus.valid        <= 1'b0;
    msg_bus.session_slot <= '0;
    msg_bus.msg_id       <= '0;
    msg_bus.req_id       <= '0;
    msg_bus.arrival_time <= '0;
    msg_bus.is_authed    <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_WINDOW_TICKS;
    cfg_wdata_i          <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // whitelist, auth check, window wrap and expiry under reset settings
    send_msg(8'd0,   HEARTBEAT_ID_RST, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_msg(8'd0,   LOGIN_ID_RST,     32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_msg(8'd0,   ECHO_ID_RST,      32'h0000_0001, 32'd5,         1'b0);
    send_msg(8'd255, 16'hFFFF,         32'h0000_0002, 32'hFFFF_FFFF, 1'b0);
    send_msg(8'd255, 16'hFFFF,         32'h0000_0003, 32'hFFFF_FFFF, 1'b1);
    send_msg(8'd255, 16'h0000,         32'h0000_0004, 32'd998,       1'b1);
    send_msg(8'd255, 16'h0000,         32'h0000_0005, 32'd999,       1'b1);
    send_msg(8'd9,   16'h0100,         32'h0000_0006, 32'h0000_0000, 1'b1);

    // limit reached, heartbeat bypass, restart on expiry
    load_regs(32'd50, 16'd2, 16'h0010, 16'h0020, 16'h0030);
    send_msg(8'd7, 16'h0100, 32'h0000_0010, 32'd10, 1'b1);
    send_msg(8'd7, 16'h0100, 32'h0000_0011, 32'd11, 1'b1);
    send_msg(8'd7, 16'h0100, 32'h0000_0012, 32'd12, 1'b1);
    send_msg(8'd7, 16'h0010, 32'h0000_0013, 32'd13, 1'b0);
    send_msg(8'd7, 16'h0020, 32'h0000_0014, 32'd59, 1'b0);
    send_msg(8'd7, 16'h0100, 32'h0000_0015, 32'd60, 1'b1);

    // zero limit, widest window, extreme ids
    load_regs(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'h0000, 16'h0000);
    send_msg(8'd3, 16'h0000, 32'h0000_0020, 32'd100, 1'b0);
    send_msg(8'd3, 16'hFFFF, 32'h0000_0021, 32'd101, 1'b0);
    send_msg(8'd3, 16'h5555, 32'h0000_0022, 32'd102, 1'b1);
    send_msg(8'd3, 16'hAAAA, 32'h0000_0023, 32'd103, 1'b0);

    // zero window, all whitelist ids equal
    load_regs(32'd0, 16'd1, 16'h1234, 16'h1234, 16'h1234);
    send_msg(8'd200, 16'h0100, 32'h0000_0030, 32'd100, 1'b1);
    send_msg(8'd200, 16'h0100, 32'h0000_0031, 32'd100, 1'b1);
    send_msg(8'd200, 16'h0100, 32'h0000_0032, 32'd100, 1'b1);
    send_msg(8'd200, 16'h1234, 32'h0000_0033, 32'd100, 1'b0);
    send_msg(8'd200, 16'h1235, 32'h0000_0034, 32'd100, 1'b0);

    load_regs(32'd1000, 16'd8, 16'd1, 16'd2, 16'd3);
    run_phase(120, 30, 1'b1);
    load_regs(32'd16, 16'd3, 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(120, 2, 1'b1);
    load_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
    run_phase(120, 1 << 20, 1'b0);
    load_regs(32'd1, 16'd1, 16'h4321, 16'h4321, 16'($urandom));
    run_phase(120, 1, 1'b1);
    load_regs(32'd0, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(120, 3, 1'b1);
    load_regs(32'd300, 16'd12, 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(120, 10, 1'b1);
    load_regs(32'd5000, 16'd20, 16'd7, 16'd8, 16'd9);
    run_phase(120, 30, 1'b0);

    quiesce();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d messages under %0d register settings", n_msgs, n_settings + 1);
    $display("verdicts seen: %0d admitted, %0d authentication required, %0d rate limited",
             n_admit, n_auth, n_rate);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
